[hdl/qise_pkg.sv]
// ----------------------------------------------------------------------------
// qise_pkg: shared types, constants and edge tables
// Widths, edge naming and the case-code tables of the isoline segment block.
// ----------------------------------------------------------------------------
package qise_pkg;

	localparam int VALUE_BITS      = 16;
	localparam int FRACTION_BITS   = 16;
	localparam int CELL_INDEX_BITS = 24;

	// case codes, named by the corners that lie above the iso level
	localparam logic [3:0] CASE_EMPTY    = 4'd0;
	localparam logic [3:0] CASE_C0       = 4'd1;
	localparam logic [3:0] CASE_C1       = 4'd2;
	localparam logic [3:0] CASE_C01      = 4'd3;
	localparam logic [3:0] CASE_C2       = 4'd4;
	localparam logic [3:0] CASE_SADDLE_A = 4'd5;
	localparam logic [3:0] CASE_C12      = 4'd6;
	localparam logic [3:0] CASE_C012     = 4'd7;
	localparam logic [3:0] CASE_C3       = 4'd8;
	localparam logic [3:0] CASE_C03      = 4'd9;
	localparam logic [3:0] CASE_SADDLE_B = 4'd10;
	localparam logic [3:0] CASE_C013     = 4'd11;
	localparam logic [3:0] CASE_C23      = 4'd12;
	localparam logic [3:0] CASE_C023     = 4'd13;
	localparam logic [3:0] CASE_C123     = 4'd14;
	localparam logic [3:0] CASE_FULL     = 4'd15;

	localparam logic [1:0] CORNER_0 = 2'd0;
	localparam logic [1:0] CORNER_1 = 2'd1;
	localparam logic [1:0] CORNER_2 = 2'd2;
	localparam logic [1:0] CORNER_3 = 2'd3;

	// the four cell edges, each measured from its lower-numbered corner
	typedef enum logic [1:0] {
		EDGE_01,
		EDGE_12,
		EDGE_03,
		EDGE_23
	} qise_edge_t;

	typedef struct packed {
		logic [3:0]                 code;
		logic [CELL_INDEX_BITS-1:0] cell_id;
	} qise_side_t;

	typedef struct packed {
		qise_edge_t start_edge;
		qise_edge_t end_edge;
	} qise_seg_t;

	function automatic logic [1:0] edge_from(input qise_edge_t e);
		logic [1:0] c;
		unique case (e)
			EDGE_01: c = CORNER_0;
			EDGE_12: c = CORNER_1;
			EDGE_03: c = CORNER_0;
			EDGE_23: c = CORNER_2;
			default: c = CORNER_0;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] edge_to(input qise_edge_t e);
		logic [1:0] c;
		unique case (e)
			EDGE_01: c = CORNER_1;
			EDGE_12: c = CORNER_2;
			EDGE_03: c = CORNER_3;
			EDGE_23: c = CORNER_3;
			default: c = CORNER_1;
		endcase
		return c;
	endfunction

	// edges of segment seg (0 or 1) for a case code
	function automatic qise_seg_t seg_edges(input logic [3:0] code, input logic seg);
		qise_seg_t s;
		unique case (code) inside
			CASE_C0, CASE_C123:   s = '{EDGE_01, EDGE_03};
			CASE_C1, CASE_C023:   s = '{EDGE_01, EDGE_12};
			CASE_C01, CASE_C23:   s = '{EDGE_03, EDGE_12};
			CASE_C2, CASE_C013:   s = '{EDGE_12, EDGE_23};
			CASE_C12, CASE_C03:   s = '{EDGE_01, EDGE_23};
			CASE_C012, CASE_C3:   s = '{EDGE_03, EDGE_23};
			CASE_SADDLE_A: s = seg ? '{EDGE_12, EDGE_23} : '{EDGE_01, EDGE_03};
			CASE_SADDLE_B: s = seg ? '{EDGE_03, EDGE_23} : '{EDGE_01, EDGE_12};
			default: s = '{EDGE_01, EDGE_01};
		endcase
		return s;
	endfunction

endpackage

[hdl/qise_front.sv]
// ----------------------------------------------------------------------------
// qise_front: input capture, case code and edge magnitudes
// Registers the request, then forms the case code and |iso-va|, |vb-va| per edge.
// ----------------------------------------------------------------------------
module qise_front import qise_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        take,
	input  logic [VALUE_BITS-1:0]       iso,
	input  logic [VALUE_BITS-1:0]       v0,
	input  logic [VALUE_BITS-1:0]       v1,
	input  logic [VALUE_BITS-1:0]       v2,
	input  logic [VALUE_BITS-1:0]       v3,
	input  logic [CELL_INDEX_BITS-1:0]  cell_in,
	output logic                        valid_s2,
	output qise_side_t                  side_s2,
	output logic [VALUE_BITS-1:0]       num_s2 [4],
	output logic [VALUE_BITS-1:0]       den_s2 [4]
);

	logic                       valid_s1;
	logic signed [VALUE_BITS-1:0] iso_s1;
	logic signed [VALUE_BITS-1:0] v_s1 [4];
	logic [CELL_INDEX_BITS-1:0] cell_s1;

	logic [3:0]            code;
	logic [VALUE_BITS-1:0] num [4];
	logic [VALUE_BITS-1:0] den [4];

	function automatic logic [VALUE_BITS-1:0] absdiff(
		input logic signed [VALUE_BITS-1:0] a,
		input logic signed [VALUE_BITS-1:0] b
	);
		logic signed [VALUE_BITS:0] d;
		d = $signed({a[VALUE_BITS-1], a}) - $signed({b[VALUE_BITS-1], b});
		return d[VALUE_BITS] ? VALUE_BITS'(-d) : d[VALUE_BITS-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			iso_s1  <= iso;
			v_s1[0] <= v0;
			v_s1[1] <= v1;
			v_s1[2] <= v2;
			v_s1[3] <= v3;
			cell_s1 <= cell_in;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			code[i] = v_s1[i] > iso_s1;
		end
		// edges in qise_edge_t order: 0-1, 1-2, 0-3, 2-3
		num[EDGE_01] = absdiff(iso_s1, v_s1[0]);
		den[EDGE_01] = absdiff(v_s1[1], v_s1[0]);
		num[EDGE_12] = absdiff(iso_s1, v_s1[1]);
		den[EDGE_12] = absdiff(v_s1[2], v_s1[1]);
		num[EDGE_03] = absdiff(iso_s1, v_s1[0]);
		den[EDGE_03] = absdiff(v_s1[3], v_s1[0]);
		num[EDGE_23] = absdiff(iso_s1, v_s1[2]);
		den[EDGE_23] = absdiff(v_s1[3], v_s1[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.code    <= code;
			side_s2.cell_id <= cell_s1;
			num_s2          <= num;
			den_s2          <= den;
		end
	end

endmodule

[hdl/qise_div.sv]
// ----------------------------------------------------------------------------
// qise_div: pipelined restoring divider
// One quotient bit per stage; quotient of 1.0 or more saturates, zero divisor gives 0.
// ----------------------------------------------------------------------------
module qise_div import qise_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic [VALUE_BITS-1:0]    num,
	input  logic [VALUE_BITS-1:0]    den,
	output logic [FRACTION_BITS-1:0] frac
);

	logic [VALUE_BITS-1:0]    rem_s [FRACTION_BITS+1];
	logic [FRACTION_BITS-1:0] q_s   [FRACTION_BITS+1];
	logic [VALUE_BITS-1:0]    den_s [FRACTION_BITS+1];
	logic                     max_s [FRACTION_BITS+1];
	logic                     zero_s[FRACTION_BITS+1];

	// stage 0 is the unregistered input side
	always_comb begin
		zero_s[0] = den == '0;
		max_s[0]  = (den != '0) && (num >= den);
		rem_s[0]  = (zero_s[0] || max_s[0]) ? '0 : num;
		q_s[0]    = '0;
		den_s[0]  = den;
	end

	for (genvar k = 1; k <= FRACTION_BITS; k++) begin : g_step
		logic [VALUE_BITS:0] sh;
		logic                ge;
		assign sh = {rem_s[k-1], 1'b0};
		assign ge = sh >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? VALUE_BITS'(sh - {1'b0, den_s[k-1]}) : sh[VALUE_BITS-1:0];
				q_s[k]    <= {q_s[k-1][FRACTION_BITS-2:0], ge};
				den_s[k]  <= den_s[k-1];
				max_s[k]  <= max_s[k-1];
				zero_s[k] <= zero_s[k-1];
			end
		end
	end

	assign frac = max_s[FRACTION_BITS]  ? '1 :
	              zero_s[FRACTION_BITS] ? '0 : q_s[FRACTION_BITS];

endmodule

[hdl/qise_emit.sv]
// ----------------------------------------------------------------------------
// qise_emit: output register and saddle expander
// Holds one cell's result and sends one or two segments on the output channel.
// ----------------------------------------------------------------------------
module qise_emit import qise_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tail_valid,
	input  qise_side_t                 tail_side,
	input  logic [FRACTION_BITS-1:0]   tail_frac [4],
	input  logic                       out_stall,
	output logic                       can_take,
	output logic                       out_valid,
	output logic [1:0]                 start_edge_from,
	output logic [1:0]                 start_edge_to,
	output logic [FRACTION_BITS-1:0]   start_fraction,
	output logic [1:0]                 end_edge_from,
	output logic [1:0]                 end_edge_to,
	output logic [FRACTION_BITS-1:0]   end_fraction,
	output logic [CELL_INDEX_BITS-1:0] source_cell,
	output logic                       last_segment
);

	logic                     valid_q;
	logic                     seg_q;
	qise_side_t               side_q;
	logic [FRACTION_BITS-1:0] frac_q [4];
	logic                     saddle;
	logic                     load;
	qise_seg_t                seg;

	assign saddle       = side_q.code == CASE_SADDLE_A || side_q.code == CASE_SADDLE_B;
	assign last_segment = !saddle || seg_q;
	assign can_take     = !valid_q || (!out_stall && last_segment);
	assign load         = can_take && tail_valid &&
	                      tail_side.code != CASE_EMPTY && tail_side.code != CASE_FULL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			seg_q   <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			seg_q   <= 1'b0;
		end else if (valid_q && !out_stall) begin
			valid_q <= !last_segment;
			seg_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			side_q <= tail_side;
			frac_q <= tail_frac;
		end
	end

	assign seg             = seg_edges(side_q.code, seg_q);
	assign out_valid       = valid_q;
	assign start_edge_from = edge_from(seg.start_edge);
	assign start_edge_to   = edge_to(seg.start_edge);
	assign start_fraction  = frac_q[seg.start_edge];
	assign end_edge_from   = edge_from(seg.end_edge);
	assign end_edge_to     = edge_to(seg.end_edge);
	assign end_fraction    = frac_q[seg.end_edge];
	assign source_cell     = side_q.cell_id;

endmodule

[hdl/quad_isoline_segment_extract_top.sv]
// ----------------------------------------------------------------------------
// quad_isoline_segment_extract_top: marching-squares segment extraction
// Case code, edge table and crossing fractions for one quad cell per request.
// ----------------------------------------------------------------------------
// A cell request (four signed corner values and a cell index) enters in every
// cycle while in_stall is low. Each corner strictly above iso_level sets its
// bit of a 4-bit case code; codes 0 and 15 yield no output, saddle codes 5
// and 10 yield two segments (last_segment on the second) and all others one.
// Each segment names its start and end edges by corners, giving the crossing
// fraction along each, unsigned Q0.16 from the edge's first corner, with a
// quotient of 1.0 saturated to all ones. From acceptance to the first
// segment a request passes the input register, the edge magnitudes, sixteen
// stages of a restoring divider (one quotient bit per stage, one divider per
// cell edge) and the output register. Throughput is one request per cycle
// while out_stall is low; a saddle cell stalls intake for its first segment.
// iso_level is written through the cfg channel, always ready; write it only
// while no request is in flight.
module quad_isoline_segment_extract_top import qise_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [VALUE_BITS-1:0]       iso_level,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [VALUE_BITS-1:0]       corner_value0,
	input  logic [VALUE_BITS-1:0]       corner_value1,
	input  logic [VALUE_BITS-1:0]       corner_value2,
	input  logic [VALUE_BITS-1:0]       corner_value3,
	input  logic [CELL_INDEX_BITS-1:0]  cell_number,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  start_edge_from,
	output logic [1:0]                  start_edge_to,
	output logic [FRACTION_BITS-1:0]    start_fraction,
	output logic [1:0]                  end_edge_from,
	output logic [1:0]                  end_edge_to,
	output logic [FRACTION_BITS-1:0]    end_fraction,
	output logic [CELL_INDEX_BITS-1:0]  source_cell,
	output logic                        last_segment
);

	logic [VALUE_BITS-1:0]    iso_q;
	logic                     adv;
	logic                     valid_s2;
	qise_side_t               side_s2;
	logic [VALUE_BITS-1:0]    num_s2 [4];
	logic [VALUE_BITS-1:0]    den_s2 [4];
	logic [FRACTION_BITS-1:0] frac [4];

	// sideband travelling alongside the dividers
	logic       vld_s  [FRACTION_BITS+1];
	qise_side_t side_s [FRACTION_BITS+1];

	// iso level register, write always taken
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_q <= '0;
		end else if (cfg_valid) begin
			iso_q <= iso_level;
		end
	end

	// the whole pipe advances together whenever the output register can take
	assign in_stall = !adv;

	qise_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.take     (in_valid),
		.iso      (iso_q),
		.v0       (corner_value0),
		.v1       (corner_value1),
		.v2       (corner_value2),
		.v3       (corner_value3),
		.cell_in  (cell_number),
		.valid_s2 (valid_s2),
		.side_s2  (side_s2),
		.num_s2   (num_s2),
		.den_s2   (den_s2)
	);

	for (genvar e = 0; e < 4; e++) begin : g_div
		qise_div u_div (
			.clk  (clk),
			.en   (adv),
			.num  (num_s2[e]),
			.den  (den_s2[e]),
			.frac (frac[e])
		);
	end

	assign vld_s[0]  = valid_s2;
	assign side_s[0] = side_s2;

	for (genvar k = 1; k <= FRACTION_BITS; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	qise_emit u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.tail_valid      (vld_s[FRACTION_BITS]),
		.tail_side       (side_s[FRACTION_BITS]),
		.tail_frac       (frac),
		.out_stall       (out_stall),
		.can_take        (adv),
		.out_valid       (out_valid),
		.start_edge_from (start_edge_from),
		.start_edge_to   (start_edge_to),
		.start_fraction  (start_fraction),
		.end_edge_from   (end_edge_from),
		.end_edge_to     (end_edge_to),
		.end_fraction    (end_fraction),
		.source_cell     (source_cell),
		.last_segment    (last_segment)
	);

endmodule

[hdl/qise_checker.sv]
// ----------------------------------------------------------------------------
// qise_checker: port-level assertions
// Checks output hold, saddle pairing and edge ordering on the top-level ports.
// ----------------------------------------------------------------------------
module qise_checker import qise_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [1:0]                 start_edge_from,
	input logic [1:0]                 start_edge_to,
	input logic [1:0]                 end_edge_from,
	input logic [1:0]                 end_edge_to,
	input logic [CELL_INDEX_BITS-1:0] source_cell,
	input logic                       last_segment
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(source_cell))
		else $error("stalled result dropped or changed");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_segment |=>
		out_valid && source_cell == $past(source_cell))
		else $error("second segment of saddle cell missing");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_segment |=> last_segment)
		else $error("saddle cell gave more than two segments");

	a_edges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> start_edge_from < start_edge_to && end_edge_from < end_edge_to)
		else $error("edge corners out of order");

endmodule

bind quad_isoline_segment_extract_top qise_checker u_qise_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.start_edge_from (start_edge_from),
	.start_edge_to   (start_edge_to),
	.end_edge_from   (end_edge_from),
	.end_edge_to     (end_edge_to),
	.source_cell     (source_cell),
	.last_segment    (last_segment)
);

[sim/tb_quad_isoline_segment_extract_top.sv]
// ----------------------------------------------------------------------------
// tb_quad_isoline_segment_extract_top: self-checking bench for segment extract
// Drives cell requests in bursts against a stalling receiver, predicts each
// segment from the corner values and iso level, and checks them in order.
// ----------------------------------------------------------------------------
module tb_quad_isoline_segment_extract_top;
	import qise_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_DRAIN = 40;

	typedef struct packed {
		logic [1:0]                 sf;
		logic [1:0]                 st;
		logic [FRACTION_BITS-1:0]   sfrac;
		logic [1:0]                 ef;
		logic [1:0]                 et;
		logic [FRACTION_BITS-1:0]   efrac;
		logic [CELL_INDEX_BITS-1:0] src;
		logic                       last;
	} segment_t;

	typedef struct {
		logic [VALUE_BITS-1:0]      v [4];
		logic [CELL_INDEX_BITS-1:0] idx;
		bit                         has_exp;
		segment_t                   exp_seg;
	} cell_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [VALUE_BITS-1:0] iso_level = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [VALUE_BITS-1:0] corner_value0 = '0, corner_value1 = '0;
	logic [VALUE_BITS-1:0] corner_value2 = '0, corner_value3 = '0;
	logic [CELL_INDEX_BITS-1:0] cell_number = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] start_edge_from, start_edge_to, end_edge_from, end_edge_to;
	logic [FRACTION_BITS-1:0] start_fraction, end_fraction;
	logic [CELL_INDEX_BITS-1:0] source_cell;
	logic last_segment;

	quad_isoline_segment_extract_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .iso_level(iso_level),
		.in_valid(in_valid), .in_stall(in_stall),
		.corner_value0(corner_value0), .corner_value1(corner_value1),
		.corner_value2(corner_value2), .corner_value3(corner_value3),
		.cell_number(cell_number),
		.out_valid(out_valid), .out_stall(out_stall),
		.start_edge_from(start_edge_from), .start_edge_to(start_edge_to),
		.start_fraction(start_fraction),
		.end_edge_from(end_edge_from), .end_edge_to(end_edge_to),
		.end_fraction(end_fraction),
		.source_cell(source_cell), .last_segment(last_segment)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: own copy of the iso level
	logic signed [VALUE_BITS-1:0] model_iso = '0;
	segment_t pending_segments [$];
	int errors = 0;
	bit stall_stop = 1'b0;

	// append one expected segment behind those already waiting
	function automatic void queue_segment(input segment_t s);
		pending_segments.insert(pending_segments.size(), s);
	endfunction

	// restoring division on magnitudes, saturated below 1.0
	function automatic logic [FRACTION_BITS-1:0] cross_frac(
			input logic signed [VALUE_BITS-1:0] iso,
			input logic signed [VALUE_BITS-1:0] va,
			input logic signed [VALUE_BITS-1:0] vb);
		longint num, den, rem;
		logic [FRACTION_BITS-1:0] q;
		num = longint'(iso) - longint'(va);
		den = longint'(vb) - longint'(va);
		if (num < 0) num = -num;
		if (den < 0) den = -den;
		q = '0;
		if (den == 0) return '0;
		if (num >= den) return '1;
		rem = num;
		for (int i = 0; i < FRACTION_BITS; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem -= den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic segment_t make_segment(input logic [1:0] a0, input logic [1:0] a1,
			input logic [1:0] b0, input logic [1:0] b1,
			input logic signed [VALUE_BITS-1:0] val [4],
			input logic signed [VALUE_BITS-1:0] iso,
			input logic [CELL_INDEX_BITS-1:0] src_idx, input logic last);
		segment_t s;
		s.sf = a0; s.st = a1; s.ef = b0; s.et = b1;
		s.sfrac = cross_frac(iso, val[a0], val[a1]);
		s.efrac = cross_frac(iso, val[b0], val[b1]);
		s.src = src_idx;
		s.last = last;
		return s;
	endfunction

	// queue the segments that one cell request should produce
	task automatic predict_segments(input cell_row_t r);
		logic signed [VALUE_BITS-1:0] val [4];
		logic [3:0] code;
		for (int i = 0; i < 4; i++) begin
			val[i] = r.v[i];
			code[i] = (val[i] > model_iso);
		end
		case (code) inside
			CASE_EMPTY, CASE_FULL: ;
			CASE_SADDLE_A: begin
				queue_segment(make_segment(CORNER_0, CORNER_1, CORNER_0,
					CORNER_3, val, model_iso, r.idx, 1'b0));
				queue_segment(make_segment(CORNER_1, CORNER_2, CORNER_2,
					CORNER_3, val, model_iso, r.idx, 1'b1));
			end
			CASE_SADDLE_B: begin
				queue_segment(make_segment(CORNER_0, CORNER_1, CORNER_1,
					CORNER_2, val, model_iso, r.idx, 1'b0));
				queue_segment(make_segment(CORNER_0, CORNER_3, CORNER_2,
					CORNER_3, val, model_iso, r.idx, 1'b1));
			end
			CASE_C0, CASE_C123: queue_segment(make_segment(CORNER_0, CORNER_1,
				CORNER_0, CORNER_3, val, model_iso, r.idx, 1'b1));
			CASE_C1, CASE_C023: queue_segment(make_segment(CORNER_0, CORNER_1,
				CORNER_1, CORNER_2, val, model_iso, r.idx, 1'b1));
			CASE_C01, CASE_C23: queue_segment(make_segment(CORNER_0, CORNER_3,
				CORNER_1, CORNER_2, val, model_iso, r.idx, 1'b1));
			CASE_C2, CASE_C013: queue_segment(make_segment(CORNER_1, CORNER_2,
				CORNER_2, CORNER_3, val, model_iso, r.idx, 1'b1));
			CASE_C12, CASE_C03: queue_segment(make_segment(CORNER_0, CORNER_1,
				CORNER_2, CORNER_3, val, model_iso, r.idx, 1'b1));
			// corners 0-1-2 above, or corner 3 alone
			default: queue_segment(make_segment(CORNER_0, CORNER_3,
				CORNER_2, CORNER_3, val, model_iso, r.idx, 1'b1));
		endcase
	endtask

	// write the iso level with the block idle; hold until the handshake lands
	task automatic write_iso(input logic [VALUE_BITS-1:0] lvl);
		cfg_valid <= 1'b1;
		iso_level <= lvl;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model_iso = lvl;
	endtask

	// wait until every expected segment has arrived, then drain the pipe
	task automatic drain_all();
		while (pending_segments.size() != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	// present one request and hold it until accepted
	task automatic send_cell(input cell_row_t r);
		in_valid <= 1'b1;
		corner_value0 <= r.v[0];
		corner_value1 <= r.v[1];
		corner_value2 <= r.v[2];
		corner_value3 <= r.v[3];
		cell_number <= r.idx;
		do @(posedge clk); while (in_stall);
		// the queue is filled at the accepting edge, ahead of any segment
		predict_segments(r);
	endtask

	function automatic cell_row_t mk_row(input int a, input int b, input int c,
			input int d, input int idx);
		cell_row_t r;
		r.v[0] = VALUE_BITS'(a); r.v[1] = VALUE_BITS'(b);
		r.v[2] = VALUE_BITS'(c); r.v[3] = VALUE_BITS'(d);
		r.idx = CELL_INDEX_BITS'(idx);
		r.has_exp = 1'b0;
		r.exp_seg = '0;
		return r;
	endfunction

	// random corners: mostly near the iso level so every case code shows up
	function automatic cell_row_t rand_row();
		cell_row_t r;
		int span;
		span = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(1, 600);
		for (int i = 0; i < 4; i++) begin
			if (span == 65535) r.v[i] = VALUE_BITS'($urandom());
			else r.v[i] = VALUE_BITS'(model_iso + $signed($urandom_range(0, 2 * span))
				- span);
		end
		r.idx = CELL_INDEX_BITS'($urandom());
		r.has_exp = 1'b0;
		r.exp_seg = '0;
		return r;
	endfunction

	// check each accepted segment against the oldest expectation
	always @(posedge clk) begin
		segment_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{start_edge_from, start_edge_to, start_fraction, end_edge_from,
				end_edge_to, end_fraction, source_cell, last_segment};
			if (pending_segments.size() == 0) begin
				$display("%0t: unexpected segment %p", $realtime, got);
				errors++;
			end else begin
				want = pending_segments.pop_front();
				if (got !== want) begin
					$display("%0t: segment mismatch expected %p actual %p",
						$realtime, want, got);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern: quiet stretches, light and heavy stalling
	always @(posedge clk) begin
		int phase;
		phase = int'(($time / 4000) % 3);
		if (stall_stop) out_stall <= 1'b0;
		else if (phase == 0) out_stall <= 1'b0;
		else if (phase == 1) out_stall <= ($urandom_range(0, 7) == 0);
		else out_stall <= ($urandom_range(0, 2) != 0);
	end

	initial begin
		cell_row_t dir [$];
		cell_row_t r;
		logic [VALUE_BITS-1:0] iso_set [4];
		int burst;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset level: empty, full, extremes, saddles
		dir.insert(dir.size(), mk_row(-32768, -32768, -32768, -32768, 0));
		dir.insert(dir.size(), mk_row(32767, 32767, 32767, 32767, 24'hFFFFFF));
		dir.insert(dir.size(), mk_row(0, 0, 0, 0, 1));
		r = mk_row(32767, -32768, -32768, -32768, 24'hFFFFFF);
		r.has_exp = 1'b1;
		// corner 0 alone above: both crossings fall just short of halfway
		r.exp_seg = '{CORNER_0, CORNER_1, 16'd32767, CORNER_0, CORNER_3, 16'd32767,
			24'hFFFFFF, 1'b1};
		dir.insert(dir.size(), r);
		for (int c = 1; c < 15; c++)
			dir.insert(dir.size(), mk_row(c[0] ? 100 : -100, c[1] ? 300 : -50,
				c[2] ? 32767 : -32768, c[3] ? 1 : 0, c));
		dir.insert(dir.size(), mk_row(32767, -32768, 32767, -32768, 24'h555555));
		dir.insert(dir.size(), mk_row(-32768, 32767, -32768, 32767, 24'hAAAAAA));
		dir.insert(dir.size(), mk_row(1, 0, 1, 0, 7));
		foreach (dir[i]) begin
			if (dir[i].has_exp) begin
				send_cell(dir[i]);
				// replace the predicted entry by the typed-in one
				void'(pending_segments.pop_back());
				queue_segment(dir[i].exp_seg);
			end else begin
				send_cell(dir[i]);
			end
		end
		in_valid <= 1'b0;
		drain_all();

		iso_set[0] = 16'h8000;
		iso_set[1] = 16'h7FFF;
		iso_set[2] = 16'hFFFF;
		iso_set[3] = VALUE_BITS'($urandom());
		for (int p = 0; p < 5; p++) begin
			write_iso(p < 4 ? iso_set[p] : 16'h0000);
			for (int n = 0; n < 330;) begin
				burst = $urandom_range(1, 24);
				for (int k = 0; k < burst && n < 330; k++, n++)
					send_cell(rand_row());
				in_valid <= 1'b0;
				@(posedge clk);
				// pause until the pipe is empty once per phase
				if (n > 150 && n <= 150 + burst)
					while (pending_segments.size() != 0) @(posedge clk);
				else
					repeat ($urandom_range(0, 4)) @(posedge clk);
			end
			drain_all();
		end

		stall_stop = 1'b1;
		drain_all();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
